/* src/utcal_pkg.sv */
// package: sequencer states, widths and constant tables for the calendar converter
package utcal_pkg;

  // seconds from 1970-01-01 to 2000-01-01
  localparam logic [31:0] EPOCH_2000 = 32'd946684800;

  // width of the shared subtract/compare unit, of the day count and of the seconds count
  localparam int unsigned ALU_W  = 32;
  localparam int unsigned DAYS_W = 16;
  localparam int unsigned QUO_W  = 32;

  // reciprocal multiplier: 30-bit dividend times 31-bit reciprocal
  localparam int unsigned MUL_W   = 30;
  localparam int unsigned RECIP_W = 31;
  localparam int unsigned PROD_W  = MUL_W + RECIP_W;

  localparam logic [ALU_W-1:0] DAYS_PER_YEAR = 32'd365;

  // ceil(2^34 / 15) and ceil(2^32 / 3), exact for any 30-bit dividend
  localparam logic [RECIP_W-1:0] RECIP_15 = 31'd1145324613;
  localparam logic [RECIP_W-1:0] RECIP_3  = 31'd1431655766;

  // division passes: seconds, minutes, hours
  typedef enum logic [1:0] {
    DIV_SEC  = 2'd0,
    DIV_MIN  = 2'd1,
    DIV_HOUR = 2'd2
  } div_sel_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_DIV   = 3'd1,
    S_YEAR  = 3'd2,
    S_MONTH = 3'd3,
    S_DONE  = 3'd4,
    S_REM   = 3'd5
  } state_t;

  // reciprocal of the odd part of each divisor: /60 is >>2 then /15, /24 is >>3 then /3
  function automatic logic [RECIP_W-1:0] recip(input div_sel_t sel);
    logic [RECIP_W-1:0] r;
    case (sel)
      DIV_HOUR: r = RECIP_3;
      default:  r = RECIP_15;
    endcase
    return r;
  endfunction

  // quotient times the divisor of each pass, shifts and one add or subtract
  function automatic logic [ALU_W-1:0] times_divisor(input div_sel_t sel,
                                                     input logic [ALU_W-1:0] q);
    logic [ALU_W-1:0] p;
    case (sel)
      DIV_HOUR: p = {q[ALU_W-5:0], 4'd0} + {q[ALU_W-4:0], 3'd0};
      default:  p = {q[ALU_W-7:0], 6'd0} - {q[ALU_W-3:0], 2'd0};
    endcase
    return p;
  endfunction

  // days in a month of a common year, 1 is January
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd2:    len = 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* src/unix_time_to_calendar_top.sv */
// top level: iterative unix time to calendar converter around one shared subtract/compare unit
// sequence: three division passes (reciprocal multiply, then remainder, for /60 /60 /24), then
//   one year step per whole year plus a final one, and one month step per month of the result;
//   done follows the last month step, or comes right after the accepting edge for inputs before 2000
// one conversion at a time: busy stays high through done, and the next start is accepted back in idle
// reset: synchronous active-high rst returns the sequencer to idle; result fields are not reset
module unix_time_to_calendar_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds,
  output logic        done,
  output logic [5:0]  second,
  output logic [5:0]  minute,
  output logic [4:0]  hour,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month,
  output logic [6:0]  year_offset,
  output logic        out_of_range
);

  utcal_pkg::state_t   state, state_next;
  utcal_pkg::div_sel_t div_sel;

  logic [utcal_pkg::QUO_W-1:0]  quo;
  logic [utcal_pkg::PROD_W-1:0] prod;
  logic [utcal_pkg::DAYS_W-1:0] days;
  logic [6:0]                   year;
  logic [3:0]                   mon;
  logic                         leap;

  logic [utcal_pkg::MUL_W-1:0] mul_in;
  logic [utcal_pkg::QUO_W-1:0] quot;
  logic [utcal_pkg::ALU_W-1:0] op_a, op_b;
  logic [utcal_pkg::ALU_W:0]   diff;
  logic                        borrow;
  logic                        accept;
  logic                        below_2000;
  logic [4:0]                  mlen;
  logic                        month_stop;

  assign accept     = start && !busy;
  assign below_2000 = epoch_seconds < utcal_pkg::EPOCH_2000;
  assign leap       = (year[1:0] == 2'b00);

  // month length with leap day
  always_comb begin
    mlen = utcal_pkg::month_len(mon);
    if (leap && mon == 4'd2) begin
      mlen = 5'd29;
    end
  end

  // dividend pre-shift and quotient pick for the reciprocal multiply
  always_comb begin
    if (div_sel == utcal_pkg::DIV_HOUR) begin
      mul_in = {1'b0, quo[utcal_pkg::QUO_W-1:3]};
      quot   = {3'd0, prod[utcal_pkg::PROD_W-1:32]};
    end else begin
      mul_in = quo[utcal_pkg::QUO_W-1:2];
      quot   = {5'd0, prod[utcal_pkg::PROD_W-1:34]};
    end
  end

  // shared subtract/compare unit operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      utcal_pkg::S_REM: begin
        op_a = quo;
        op_b = utcal_pkg::times_divisor(div_sel, quot);
      end
      utcal_pkg::S_YEAR: begin
        op_a = {16'd0, days};
        op_b = utcal_pkg::DAYS_PER_YEAR + {31'd0, leap};
      end
      utcal_pkg::S_MONTH: begin
        op_a = {16'd0, days};
        op_b = {27'd0, mlen};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign diff       = {1'b0, op_a} - {1'b0, op_b};
  assign borrow     = diff[utcal_pkg::ALU_W];
  assign month_stop = borrow || (mon == 4'd12);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      utcal_pkg::S_IDLE: begin
        if (accept) begin
          state_next = below_2000 ? utcal_pkg::S_DONE : utcal_pkg::S_DIV;
        end
      end
      utcal_pkg::S_DIV: begin
        state_next = utcal_pkg::S_REM;
      end
      utcal_pkg::S_REM: begin
        if (div_sel == utcal_pkg::DIV_HOUR) begin
          state_next = utcal_pkg::S_YEAR;
        end else begin
          state_next = utcal_pkg::S_DIV;
        end
      end
      utcal_pkg::S_YEAR: begin
        if (borrow) begin
          state_next = utcal_pkg::S_MONTH;
        end
      end
      utcal_pkg::S_MONTH: begin
        if (month_stop) begin
          state_next = utcal_pkg::S_DONE;
        end
      end
      utcal_pkg::S_DONE: begin
        state_next = utcal_pkg::S_IDLE;
      end
      default: begin
        state_next = utcal_pkg::S_IDLE;
      end
    endcase
  end

  // handshake outputs
  always_comb begin
    busy = (state != utcal_pkg::S_IDLE);
    done = (state == utcal_pkg::S_DONE);
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= utcal_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      utcal_pkg::S_IDLE: begin
        if (accept) begin
          quo          <= epoch_seconds - utcal_pkg::EPOCH_2000;
          div_sel      <= utcal_pkg::DIV_SEC;
          second       <= '0;
          minute       <= '0;
          hour         <= '0;
          day_of_month <= '0;
          month        <= '0;
          year_offset  <= '0;
          out_of_range <= below_2000;
        end
      end
      utcal_pkg::S_DIV: begin
        // quotient by reciprocal multiplication
        prod <= {31'd0, mul_in} * {30'd0, utcal_pkg::recip(div_sel)};
      end
      utcal_pkg::S_REM: begin
        // remainder is the dividend minus quotient times divisor
        quo <= quot;
        case (div_sel)
          utcal_pkg::DIV_SEC: begin
            second  <= diff[5:0];
            div_sel <= utcal_pkg::DIV_MIN;
          end
          utcal_pkg::DIV_MIN: begin
            minute  <= diff[5:0];
            div_sel <= utcal_pkg::DIV_HOUR;
          end
          default: begin
            hour <= diff[4:0];
            days <= quot[utcal_pkg::DAYS_W-1:0];
            year <= '0;
          end
        endcase
      end
      utcal_pkg::S_YEAR: begin
        // subtract whole years until the remaining days fit
        if (borrow) begin
          mon <= 4'd1;
        end else begin
          days <= diff[utcal_pkg::DAYS_W-1:0];
          year <= year + 7'd1;
        end
      end
      utcal_pkg::S_MONTH: begin
        // subtract whole months; December takes the rest
        if (month_stop) begin
          day_of_month <= days[4:0] + 5'd1;
          month        <= mon;
          year_offset  <= year;
        end else begin
          days <= diff[utcal_pkg::DAYS_W-1:0];
          mon  <= mon + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after transaction accepted");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done strobe longer than one cycle");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (done && out_of_range) |-> (second == 6'd0 && minute == 6'd0 && hour == 5'd0 &&
      day_of_month == 5'd0 && month == 4'd0 && year_offset == 7'd0))
    else $error("out of range result with nonzero fields");

  a_date_valid: assert property (@(posedge clk) disable iff (rst)
    (done && !out_of_range) |-> (month != 4'd0 && month <= 4'd12 &&
      day_of_month != 5'd0 && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
    else $error("calendar fields out of range");

endmodule

/* test/unix_time_to_calendar_top_test.sv */
// testbench: unix_time_to_calendar_top checked against a built-in calendar predictor
module unix_time_to_calendar_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  // one calendar result as the block reports it
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month;
    logic [6:0] year_offset;
    logic       out_of_range;
  } calendar_t;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam longint unsigned MAX_EPOCH = 64'hFFFF_FFFF;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 200;

  // month lengths of a common year, january first
  localparam int unsigned COMMON_MONTH_DAYS [12] =
    '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] epoch_seconds;
  logic        done;
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [4:0]  day_of_month;
  logic [3:0]  month;
  logic [6:0]  year_offset;
  logic        out_of_range;

  calendar_t   pending_dates [$];
  int unsigned errors;
  int unsigned idle_pct;

  unix_time_to_calendar_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .epoch_seconds(epoch_seconds),
    .done         (done),
    .second       (second),
    .minute       (minute),
    .hour         (hour),
    .day_of_month (day_of_month),
    .month        (month),
    .year_offset  (year_offset),
    .out_of_range (out_of_range)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // leap rule of the block: every fourth year offset, 2100 included
  function automatic bit is_leap(input int unsigned yoff);
    return (yoff % 4) == 0;
  endfunction

  // expected calendar fields for one timestamp
  function automatic calendar_t predict_calendar(input logic [31:0] secs);
    calendar_t   cal;
    int unsigned rem;
    int unsigned days;
    int unsigned yoff;
    int unsigned mon;
    int unsigned len;
    cal = '0;
    if (secs < utcal_pkg::EPOCH_2000) begin
      cal.out_of_range = 1'b1;
      return cal;
    end
    rem = secs - utcal_pkg::EPOCH_2000;
    cal.second = 6'(rem % 60);
    rem = rem / 60;
    cal.minute = 6'(rem % 60);
    rem = rem / 60;
    cal.hour = 5'(rem % 24);
    days = rem / 24;
    // strip whole years
    yoff = 0;
    while (days >= 365 + int'(is_leap(yoff))) begin
      days -= 365 + int'(is_leap(yoff));
      yoff++;
    end
    // strip whole months of the final year
    mon = 1;
    forever begin
      len = COMMON_MONTH_DAYS[mon - 1] + ((mon == 2 && is_leap(yoff)) ? 1 : 0);
      if (days < len || mon >= 12) break;
      days -= len;
      mon++;
    end
    cal.day_of_month = 5'(days + 1);
    cal.month = 4'(mon);
    cal.year_offset = 7'(yoff);
    return cal;
  endfunction

  // seconds since 1970 of a calendar date; may exceed 32 bits
  function automatic longint unsigned unix_seconds_of(input int unsigned yoff,
                                                      input int unsigned mon,
                                                      input int unsigned mday,
                                                      input int unsigned hh,
                                                      input int unsigned mm,
                                                      input int unsigned ss);
    longint unsigned days;
    days = 0;
    for (int unsigned y = 0; y < yoff; y++) days += 365 + int'(is_leap(y));
    for (int unsigned m = 1; m < mon; m++) begin
      days += COMMON_MONTH_DAYS[m - 1] + ((m == 2 && is_leap(yoff)) ? 1 : 0);
    end
    days += mday - 1;
    return longint'(utcal_pkg::EPOCH_2000) + days * SECS_PER_DAY + hh * 3600 + mm * 60 + ss;
  endfunction

  // random timestamp: mostly near year and month boundaries, some anywhere
  function automatic logic [31:0] random_epoch();
    int unsigned     pick;
    longint          stamp;
    pick = $urandom_range(99);
    if (pick < 15) return $urandom;
    if (pick < 25) return $urandom_range(utcal_pkg::EPOCH_2000 - 1, 0);
    if (pick < 35) return $urandom_range(32'hFFFF_FFFF, utcal_pkg::EPOCH_2000);
    stamp = longint'(unix_seconds_of($urandom_range(106), $urandom_range(12, 1), 1, 0, 0, 0))
            + longint'($urandom_range(4 * SECS_PER_DAY)) - longint'(2 * SECS_PER_DAY);
    if (stamp < 0 || stamp > longint'(MAX_EPOCH)) begin
      return $urandom_range(32'hFFFF_FFFF, utcal_pkg::EPOCH_2000);
    end
    return 32'(stamp);
  endfunction

  // report one field mismatch
  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  // compare each result with the oldest pending date
  always @(posedge clk) begin
    calendar_t exp_cal;
    if (!rst && done) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d-%0d-%0d %0d:%0d:%0d oor=%0b",
                 $time, year_offset, month, day_of_month, hour, minute, second, out_of_range);
        errors++;
      end else begin
        exp_cal = pending_dates.pop_front();
        check_field("second", exp_cal.second, second);
        check_field("minute", exp_cal.minute, minute);
        check_field("hour", exp_cal.hour, hour);
        check_field("day_of_month", exp_cal.day_of_month, day_of_month);
        check_field("month", exp_cal.month, month);
        check_field("year_offset", exp_cal.year_offset, year_offset);
        check_field("out_of_range", exp_cal.out_of_range, out_of_range);
      end
    end
  end

  // send one transaction and record its expected date
  task automatic send_timestamp(input logic [31:0] secs);
    @(negedge clk);
    start <= 1'b1;
    epoch_seconds <= secs;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_dates.push_back(predict_calendar(secs));
  endtask

  // random sender gap, short or long so it lands on every phase of the conversion
  task automatic sender_gap();
    int unsigned n;
    if ($urandom_range(99) < idle_pct) begin
      n = $urandom_range(1) ? $urandom_range(8, 1) : $urandom_range(250, 1);
      repeat (n) @(negedge clk) start <= 1'b0;
    end
  endtask

  // hold off until every pending date has come back
  task automatic wait_drained();
    @(negedge clk) start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  // epoch boundary, field rollovers, leap days, both ends of the input range
  task automatic test_directed_edges();
    idle_pct = 0;
    send_timestamp(32'd0);
    send_timestamp(32'hFFFF_FFFF);
    send_timestamp(utcal_pkg::EPOCH_2000 - 1);
    send_timestamp(utcal_pkg::EPOCH_2000);
    send_timestamp(utcal_pkg::EPOCH_2000 + 59);
    send_timestamp(utcal_pkg::EPOCH_2000 + 60);
    send_timestamp(utcal_pkg::EPOCH_2000 + 3599);
    send_timestamp(utcal_pkg::EPOCH_2000 + SECS_PER_DAY - 1);
    send_timestamp(utcal_pkg::EPOCH_2000 + SECS_PER_DAY);
    send_timestamp(32'(unix_seconds_of(0, 2, 28, 23, 59, 59)));
    send_timestamp(32'(unix_seconds_of(0, 2, 29, 0, 0, 0)));
    send_timestamp(32'(unix_seconds_of(0, 3, 1, 0, 0, 0)));
    send_timestamp(32'(unix_seconds_of(0, 12, 31, 23, 59, 59)));
    send_timestamp(32'(unix_seconds_of(1, 1, 1, 0, 0, 0)));
    send_timestamp(32'(unix_seconds_of(1, 2, 28, 23, 59, 59)));
    send_timestamp(32'(unix_seconds_of(1, 3, 1, 0, 0, 0)));
    send_timestamp(32'(unix_seconds_of(100, 2, 29, 12, 30, 45)));
    send_timestamp(32'(unix_seconds_of(100, 12, 31, 23, 59, 59)));
    send_timestamp(32'(unix_seconds_of(105, 12, 31, 23, 59, 59)));
    send_timestamp(32'(unix_seconds_of(106, 1, 1, 0, 0, 0)));
    send_timestamp(32'h7FFF_FFFF);
    send_timestamp(32'h8000_0000);
    send_timestamp(32'hFFFF_FFFE);
    wait_drained();
  endtask

  // random timestamps at a given sender idle rate
  task automatic test_random_phase(input int unsigned pct, input int unsigned count);
    idle_pct = pct;
    repeat (count) begin
      send_timestamp(random_epoch());
      sender_gap();
    end
  endtask

  // stimulus sequence and final verdict
  initial begin
    int unsigned waited;
    errors = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    epoch_seconds = '0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_directed_edges();
    test_random_phase(0, ITEMS_PER_PHASE);
    test_random_phase(48, ITEMS_PER_PHASE);
    wait_drained();
    test_random_phase(0, ITEMS_PER_PHASE);
    test_random_phase(11, ITEMS_PER_PHASE);

    // drain, then watch for stray results
    @(negedge clk) start <= 1'b0;
    waited = 0;
    while (pending_dates.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (pending_dates.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_dates.size());
      errors++;
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule
